FILE: hdl/adb_pkg.sv
// Package: word types, command codes and result codes for the ADB message deframer.
package adb_pkg;

  localparam int unsigned HdrBytes  = 24;
  localparam int unsigned LimitW    = 21;
  localparam int unsigned CountW    = 5;

  // Command words as they appear little-endian on the wire.
  localparam logic [31:0] CmdSync = 32'h434e5953;
  localparam logic [31:0] CmdCnxn = 32'h4e584e43;
  localparam logic [31:0] CmdOpen = 32'h4e45504f;
  localparam logic [31:0] CmdOkay = 32'h59414b4f;
  localparam logic [31:0] CmdClse = 32'h45534c43;
  localparam logic [31:0] CmdWrte = 32'h45545257;
  localparam logic [31:0] CmdAuth = 32'h48545541;
  localparam logic [31:0] CmdStls = 32'h534c5453;
  localparam logic [31:0] AllOnes = 32'hffffffff;

  localparam logic [3:0] ClsSync    = 4'd0;
  localparam logic [3:0] ClsCnxn    = 4'd1;
  localparam logic [3:0] ClsOpen    = 4'd2;
  localparam logic [3:0] ClsOkay    = 4'd3;
  localparam logic [3:0] ClsClse    = 4'd4;
  localparam logic [3:0] ClsWrte    = 4'd5;
  localparam logic [3:0] ClsAuth    = 4'd6;
  localparam logic [3:0] ClsStls    = 4'd7;
  localparam logic [3:0] ClsUnknown = 4'd8;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusBadMagic = 2'd1;
  localparam logic [1:0] StatusTooLong  = 2'd2;

  // Header word slots, selected by header byte count divided by four.
  localparam logic [2:0] SlotCommand = 3'd0;
  localparam logic [2:0] SlotArg0    = 3'd1;
  localparam logic [2:0] SlotArg1    = 3'd2;
  localparam logic [2:0] SlotLength  = 3'd3;
  localparam logic [2:0] SlotMagic   = 3'd5;

  localparam logic [CountW-1:0] HdrLast = CountW'(HdrBytes - 1);
  localparam logic [CountW-1:0] HdrDone = CountW'(HdrBytes);

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       direction;
    logic       segment_end;
  } adb_in_t;

  typedef struct packed {
    logic              msg_direction;
    logic [1:0]        status;
    logic [3:0]        command_class;
    logic [31:0]       first_arg;
    logic [31:0]       second_arg;
    logic [LimitW-1:0] payload_length;
    logic [1:0]        auth_kind;
    logic              tls_done;
  } adb_res_t;

  function automatic logic [3:0] class_of(input logic [31:0] cmd);
    logic [3:0] cls;
    case (cmd)
      CmdSync: cls = ClsSync;
      CmdCnxn: cls = ClsCnxn;
      CmdOpen: cls = ClsOpen;
      CmdOkay: cls = ClsOkay;
      CmdClse: cls = ClsClse;
      CmdWrte: cls = ClsWrte;
      CmdAuth: cls = ClsAuth;
      CmdStls: cls = ClsStls;
      default: cls = ClsUnknown;
    endcase
    return cls;
  endfunction

endpackage

FILE: hdl/adb_chan_if.sv
// Interface: valid/ready channel carrying one word of a packed payload type.
interface adb_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/adb_parse_core.sv
// Module: per-direction header gathering, checks, payload count and TLS handoff state.
module adb_parse_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     fire_i,
  input  adb_pkg::adb_in_t         item_i,
  input  logic [adb_pkg::LimitW-1:0] buffer_limit_i,
  output logic                     res_valid_o,
  output adb_pkg::adb_res_t        res_o
);
  import adb_pkg::*;

  logic [CountW-1:0] hc_q   [2];
  logic [CountW-1:0] hc_d   [2];
  logic [LimitW-1:0] left_q [2];
  logic [LimitW-1:0] left_d [2];
  logic [31:0]       cmd_q  [2];
  logic [31:0]       cmd_d  [2];
  logic [31:0]       arg0_q [2];
  logic [31:0]       arg0_d [2];
  logic [31:0]       arg1_q [2];
  logic [31:0]       arg1_d [2];
  logic [31:0]       len_q  [2];
  logic [31:0]       len_d  [2];
  logic [31:0]       magic_q[2];
  logic [31:0]       magic_d[2];
  logic [1:0]        disc_q, disc_d;
  logic [1:0]        stls_q, stls_d;
  logic              tls_q, tls_d;
  logic              handed_q, handed_d;

  logic              dir;
  logic [LimitW-1:0] max_pay;
  logic [31:0]       magic_new;
  logic              emit_msg;

  assign dir = item_i.direction;
  assign max_pay = (buffer_limit_i >= LimitW'(HdrBytes)) ?
                   buffer_limit_i - LimitW'(HdrBytes) : '0;
  assign magic_new = {item_i.stream_byte, magic_q[dir][31:8]};

  always_comb begin
    hc_d     = hc_q;
    left_d   = left_q;
    cmd_d    = cmd_q;
    arg0_d   = arg0_q;
    arg1_d   = arg1_q;
    len_d    = len_q;
    magic_d  = magic_q;
    disc_d   = disc_q;
    stls_d   = stls_q;
    tls_d    = tls_q;
    handed_d = handed_q;
    emit_msg = 1'b0;
    res_valid_o = 1'b0;
    res_o = '0;
    res_o.msg_direction = dir;

    if (fire_i && !handed_q) begin
      if (disc_q[dir]) begin
        if (item_i.segment_end) begin
          disc_d[dir] = 1'b0;
        end
      end else if (hc_q[dir] < HdrDone) begin
        // Header bytes arrive least significant first, so each word shifts right.
        case (hc_q[dir][4:2])
          SlotCommand: cmd_d[dir]   = {item_i.stream_byte, cmd_q[dir][31:8]};
          SlotArg0:    arg0_d[dir]  = {item_i.stream_byte, arg0_q[dir][31:8]};
          SlotArg1:    arg1_d[dir]  = {item_i.stream_byte, arg1_q[dir][31:8]};
          SlotLength:  len_d[dir]   = {item_i.stream_byte, len_q[dir][31:8]};
          SlotMagic:   magic_d[dir] = magic_new;
          default: ;
        endcase
        hc_d[dir] = hc_q[dir] + CountW'(1);
        if (hc_q[dir] == HdrLast) begin
          if (magic_new != (cmd_q[dir] ^ AllOnes)) begin
            res_valid_o = 1'b1;
            res_o.status = StatusBadMagic;
            hc_d[dir] = '0;
            disc_d[dir] = !item_i.segment_end;
          end else if (len_q[dir] > {{(32-LimitW){1'b0}}, max_pay}) begin
            res_valid_o = 1'b1;
            res_o.status = StatusTooLong;
            hc_d[dir] = '0;
            disc_d[dir] = !item_i.segment_end;
          end else if (len_q[dir] == '0) begin
            emit_msg = 1'b1;
            hc_d[dir] = '0;
          end else begin
            left_d[dir] = len_q[dir][LimitW-1:0];
          end
        end
      end else begin
        if (left_q[dir] != '0) begin
          left_d[dir] = left_q[dir] - LimitW'(1);
        end
        if (left_q[dir] <= LimitW'(1)) begin
          emit_msg = 1'b1;
          hc_d[dir] = '0;
        end
      end

      if (emit_msg) begin
        if (cmd_q[dir] == CmdStls) begin
          stls_d[dir] = 1'b1;
          if (stls_q[!dir]) begin
            tls_d = 1'b1;
          end
        end
        res_valid_o = 1'b1;
        res_o.status = StatusOk;
        res_o.command_class = class_of(cmd_q[dir]);
        res_o.first_arg = arg0_q[dir];
        res_o.second_arg = arg1_q[dir];
        res_o.payload_length = len_q[dir][LimitW-1:0];
        if (cmd_q[dir] == CmdAuth && (arg0_q[dir] inside {[32'd1:32'd3]})) begin
          res_o.auth_kind = arg0_q[dir][1:0];
        end
      end
      res_o.tls_done = tls_d;

      if (item_i.segment_end && tls_d) begin
        handed_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q     <= '{default: '0};
      left_q   <= '{default: '0};
      disc_q   <= '0;
      stls_q   <= '0;
      tls_q    <= 1'b0;
      handed_q <= 1'b0;
    end else begin
      hc_q     <= hc_d;
      left_q   <= left_d;
      disc_q   <= disc_d;
      stls_q   <= stls_d;
      tls_q    <= tls_d;
      handed_q <= handed_d;
    end
  end

  // Header words are fully rewritten before each use, so they carry no reset.
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    arg0_q  <= arg0_d;
    arg1_q  <= arg1_d;
    len_q   <= len_d;
    magic_q <= magic_d;
  end

  a_handoff_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    handed_q |=> handed_q) else $error("handoff flag cleared");

  a_tls_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tls_q |=> tls_q) else $error("TLS flag cleared");

  a_no_result_after_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    handed_q |-> !res_valid_o) else $error("result after handoff");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hc_q[0] <= HdrDone) && (hc_q[1] <= HdrDone)) else $error("header count overrun");

  a_tls_needs_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tls_q |-> (stls_q == 2'b11)) else $error("TLS done without both STLS");

endmodule

FILE: hdl/adb_message_deframer_unit.sv
// ADB message deframer: a byte stream in, one word per finished or failed message out.
//
// in_i carries one connection byte per word, tagged with the sending side and
// a mark on the last byte of a delivered segment. res_o carries one word per
// complete message (command class, arguments, length, auth type) or per header
// that fails the magic or length check. cfg_we_i/cfg_wdata_i write the
// reassembly buffer limit; write it only while the block is idle.
//
// A byte is taken into an input register, then processed against the
// per-direction parse state, and any result lands in the output register.
// One byte is accepted every cycle while no result is held up at the output;
// the parse state for each byte is computed combinationally and registered.
//
// Reset clears parse state (not header words) and sets the limit to 65536.
// When the receiver stalls with a result pending, one further byte waits in
// the input register and in_i.ready falls until the result is taken; bytes
// that give no result keep flowing while the output is idle. After both sides
// have sent STLS and a segment ends, every later byte is accepted and dropped.
module adb_message_deframer_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [adb_pkg::LimitW-1:0] cfg_wdata_i,
  adb_chan_if.sink                   in_i,
  adb_chan_if.source                 res_o
);
  import adb_pkg::*;

  logic              lim_q;
  logic [LimitW-1:0] limit_q;
  logic              in_vld_q;
  adb_in_t           in_item_q;
  logic              res_vld_q;
  adb_res_t          res_q;
  logic              proc;
  logic              core_valid;
  adb_res_t          core_res;

  assign proc = in_vld_q && (!res_vld_q || res_o.ready);
  assign in_i.ready = !in_vld_q || proc;
  assign res_o.valid = res_vld_q;
  assign res_o.data = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitW'(65536);
      lim_q   <= 1'b0;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
      lim_q   <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (proc) begin
        res_vld_q <= core_valid;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q <= in_i.data;
    end
    if (proc && core_valid) begin
      res_q <= core_res;
    end
  end

  adb_parse_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (proc),
    .item_i         (in_item_q),
    .buffer_limit_i (limit_q),
    .res_valid_o    (core_valid),
    .res_o          (core_res)
  );

  // Once the limit has been written since reset, its write flag stays set.
  a_limit_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lim_q |=> lim_q) else $error("limit write flag cleared");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && !res_o.ready) |=> (res_vld_q && $stable(res_q)))
    else $error("pending result lost");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> in_i.ready) else $error("input stalled while empty");

endmodule

FILE: test/adb_deframer_monitor.sv
// Deframer monitor: predicts the result words from accepted bytes and compares them.
`timescale 1ns / 100ps

module adb_deframer_monitor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [adb_pkg::LimitW-1:0] cfg_wdata_i,
  adb_chan_if                        in_mon,
  adb_chan_if                        res_mon,
  output int                         pending_o,
  output int                         fail_count_o
);
  import adb_pkg::*;

  // The table order gives the command class.
  localparam logic [31:0] KnownCmds [8] = '{CmdSync, CmdCnxn, CmdOpen, CmdOkay,
                                           CmdClse, CmdWrte, CmdAuth, CmdStls};

  logic [LimitW-1:0] buf_limit;
  logic [CountW-1:0] hdr_cnt   [2];
  logic [31:0]       cmd_w     [2];
  logic [31:0]       arg0_w    [2];
  logic [31:0]       arg1_w    [2];
  logic [31:0]       len_w     [2];
  logic [31:0]       magic_w   [2];
  logic [LimitW-1:0] pay_left  [2];
  logic              skip_seg  [2];
  logic              stls_from [2];
  logic              tls_both;
  logic              handed_off;
  adb_res_t          expected_msgs [$];
  int                mismatches;

  function automatic adb_res_t error_word(input logic d, input logic [1:0] code);
    adb_res_t r;
    r               = '0;
    r.msg_direction = d;
    r.status        = code;
    r.tls_done      = tls_both;
    return r;
  endfunction

  function automatic adb_res_t message_word(input logic d);
    adb_res_t r;
    r = '0;
    if (cmd_w[d] == CmdStls) begin
      stls_from[d] = 1'b1;
      if (stls_from[0] && stls_from[1]) tls_both = 1'b1;
    end
    r.msg_direction = d;
    r.status        = StatusOk;
    r.command_class = ClsUnknown;
    for (int i = 0; i < 8; i++) begin
      if (cmd_w[d] == KnownCmds[i]) r.command_class = 4'(i);
    end
    r.first_arg      = arg0_w[d];
    r.second_arg     = arg1_w[d];
    r.payload_length = len_w[d][LimitW-1:0];
    if (cmd_w[d] == CmdAuth && arg0_w[d] >= 32'd1 && arg0_w[d] <= 32'd3) begin
      r.auth_kind = arg0_w[d][1:0];
    end
    r.tls_done = tls_both;
    return r;
  endfunction

  function automatic void parse_byte(input adb_in_t w);
    logic        d;
    logic [31:0] max_payload;
    logic        emit;
    adb_res_t    r;
    d    = w.direction;
    emit = 1'b0;
    r    = '0;
    if (handed_off) return;
    if (skip_seg[d]) begin
      if (w.segment_end) begin
        skip_seg[d] = 1'b0;
        if (tls_both) handed_off = 1'b1;
      end
      return;
    end
    if (hdr_cnt[d] < HdrDone) begin
      case (hdr_cnt[d][4:2])
        SlotCommand: cmd_w[d]   = {w.stream_byte, cmd_w[d][31:8]};
        SlotArg0:    arg0_w[d]  = {w.stream_byte, arg0_w[d][31:8]};
        SlotArg1:    arg1_w[d]  = {w.stream_byte, arg1_w[d][31:8]};
        SlotLength:  len_w[d]   = {w.stream_byte, len_w[d][31:8]};
        SlotMagic:   magic_w[d] = {w.stream_byte, magic_w[d][31:8]};
        default: ;
      endcase
      if (hdr_cnt[d] == HdrLast) begin
        max_payload = (buf_limit >= HdrBytes) ? 32'(buf_limit) - HdrBytes : 32'd0;
        if (magic_w[d] != (cmd_w[d] ^ AllOnes)) begin
          r           = error_word(d, StatusBadMagic);
          emit        = 1'b1;
          hdr_cnt[d]  = '0;
          skip_seg[d] = !w.segment_end;
        end else if (len_w[d] > max_payload) begin
          r           = error_word(d, StatusTooLong);
          emit        = 1'b1;
          hdr_cnt[d]  = '0;
          skip_seg[d] = !w.segment_end;
        end else if (len_w[d] == 32'd0) begin
          r          = message_word(d);
          emit       = 1'b1;
          hdr_cnt[d] = '0;
        end else begin
          pay_left[d] = len_w[d][LimitW-1:0];
          hdr_cnt[d]  = HdrDone;
        end
      end else begin
        hdr_cnt[d] = hdr_cnt[d] + 1'b1;
      end
    end else begin
      if (pay_left[d] != '0) pay_left[d] = pay_left[d] - 1'b1;
      if (pay_left[d] == '0) begin
        r          = message_word(d);
        emit       = 1'b1;
        hdr_cnt[d] = '0;
      end
    end
    if (w.segment_end && tls_both) handed_off = 1'b1;
    if (emit) expected_msgs.push_back(r);
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_word(input adb_res_t got);
    adb_res_t want;
    if (expected_msgs.size() == 0) begin
      $error("result word with nothing expected: %h", got);
      mismatches++;
      return;
    end
    want = expected_msgs.pop_front();
    compare_field("msg_direction", 32'(want.msg_direction), 32'(got.msg_direction));
    compare_field("status", 32'(want.status), 32'(got.status));
    compare_field("command_class", 32'(want.command_class), 32'(got.command_class));
    compare_field("first_arg", want.first_arg, got.first_arg);
    compare_field("second_arg", want.second_arg, got.second_arg);
    compare_field("payload_length", 32'(want.payload_length), 32'(got.payload_length));
    compare_field("auth_kind", 32'(want.auth_kind), 32'(got.auth_kind));
    compare_field("tls_done", 32'(want.tls_done), 32'(got.tls_done));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_limit = LimitW'(65536);
      for (int i = 0; i < 2; i++) begin
        hdr_cnt[i]   = '0;
        cmd_w[i]     = '0;
        arg0_w[i]    = '0;
        arg1_w[i]    = '0;
        len_w[i]     = '0;
        magic_w[i]   = '0;
        pay_left[i]  = '0;
        skip_seg[i]  = 1'b0;
        stls_from[i] = 1'b0;
      end
      tls_both   = 1'b0;
      handed_off = 1'b0;
      expected_msgs.delete();
      mismatches = 0;
    end else begin
      if (cfg_we_i) buf_limit = cfg_wdata_i;
      // A result always trails its byte, so checking first is safe.
      if (res_mon.valid && res_mon.ready) check_word(res_mon.data);
      if (in_mon.valid && in_mon.ready) parse_byte(in_mon.data);
    end
    pending_o    <= expected_msgs.size();
    fail_count_o <= mismatches;
  end

endmodule

FILE: test/testbench.sv
// Testbench top: drives bytes and limit writes into the deframer and gives the verdict.
`timescale 1ns / 100ps

module testbench;
  import adb_pkg::*;

  localparam int IdleLimit = 2000;
  localparam logic [31:0] KnownCmds [8] = '{CmdSync, CmdCnxn, CmdOpen, CmdOkay,
                                           CmdClse, CmdWrte, CmdAuth, CmdStls};

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [LimitW-1:0] cfg_wdata;
  int                pending;
  int                fail_count;
  int                idle_cycles = 0;

  logic [LimitW-1:0] cur_limit = LimitW'(65536);
  adb_in_t           lane0_q [$];
  adb_in_t           lane1_q [$];
  int                sent = 0;
  int                burst_left = 0;
  logic [15:0]       stall_mask = '0;
  int                stall_left = 0;

  adb_chan_if #(.payload_t(adb_in_t))  in_ch ();
  adb_chan_if #(.payload_t(adb_res_t)) res_ch ();

  adb_message_deframer_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_ch),
    .res_o      (res_ch)
  );

  adb_deframer_monitor monitor (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_mon      (in_ch),
    .res_mon     (res_ch),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: a rotating stall mask, replaced when its random run length expires.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left == 0) begin
        stall_left = $urandom_range(50, 300);
        case ($urandom_range(0, 3))
          0:       stall_mask = '0;
          1:       stall_mask = 16'($urandom) & 16'h7fff;
          2:       stall_mask = 16'($urandom) & 16'($urandom) & 16'h7fff;
          default: stall_mask = (16'($urandom) | 16'($urandom)) & 16'h7fff;
        endcase
      end
      stall_left--;
      stall_mask = {stall_mask[0], stall_mask[15:1]};
      res_ch.ready <= !stall_mask[0];
    end
  end

  function automatic logic [31:0] payload_cap();
    return (cur_limit >= HdrBytes) ? 32'(cur_limit) - HdrBytes : 32'd0;
  endfunction

  function automatic void add_byte(input logic d, input logic [7:0] b, input logic se);
    adb_in_t w;
    w.stream_byte = b;
    w.direction   = d;
    w.segment_end = se;
    if (d) lane1_q.push_back(w);
    else   lane0_q.push_back(w);
  endfunction

  // A failing header is followed by junk that ends the segment; a good one by its payload.
  function automatic void build_message(input logic d, input logic [31:0] cmd,
                                        input logic [31:0] a0, input logic [31:0] a1,
                                        input logic [31:0] len, input logic bad_magic,
                                        input int junk, input logic loose_se);
    logic [31:0] hdr [6];
    logic        failing;
    int          tail;
    logic        se;
    hdr[0]  = cmd;
    hdr[1]  = a0;
    hdr[2]  = a1;
    hdr[3]  = len;
    hdr[4]  = $urandom;
    hdr[5]  = bad_magic ? ~cmd ^ (32'd1 << $urandom_range(0, 31)) : ~cmd;
    failing = bad_magic || (len > payload_cap());
    tail    = failing ? junk : int'(len);
    for (int i = 0; i < HdrBytes + tail; i++) begin
      if (i == HdrBytes + tail - 1) begin
        se = failing ? 1'b1 : (loose_se && $urandom_range(0, 1) == 0);
      end else begin
        se = !failing && loose_se && $urandom_range(0, 9) == 0;
      end
      add_byte(d, (i < HdrBytes) ? hdr[i / 4][8 * (i % 4) +: 8] : 8'($urandom), se);
    end
  endfunction

  function automatic void random_message(input logic d);
    int          kind;
    int          sel;
    int          n;
    logic [31:0] cmd;
    logic [31:0] a0;
    logic [31:0] cap;
    logic [31:0] len;
    kind = $urandom_range(0, 99);
    sel  = $urandom_range(0, 8);
    cmd  = (sel == 8) ? 32'($urandom) : KnownCmds[sel];
    // TLS on the second side is kept for the closing sequence.
    if (d && cmd == CmdStls) cmd = CmdWrte;
    a0  = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 5)) : 32'($urandom);
    cap = payload_cap();
    if (kind < 70) begin
      len = ($urandom_range(0, 7) == 0) ? 32'($urandom_range(0, 40)) :
                                           32'($urandom_range(0, 8));
      if (len > cap) len = cap;
      build_message(d, cmd, a0, $urandom, len, 1'b0, 0, 1'b1);
    end else if (kind < 82) begin
      build_message(d, cmd, a0, $urandom, 32'($urandom_range(0, 8)), 1'b1,
                    $urandom_range(0, 6), 1'b1);
    end else if (kind < 92) begin
      len = ($urandom_range(0, 1) == 0) ? cap + 32'd1 : (32'($urandom) | 32'h8000_0000);
      build_message(d, cmd, a0, $urandom, len, 1'b0, $urandom_range(0, 6), 1'b1);
    end else begin
      n = $urandom_range(HdrBytes, 40);
      for (int i = 0; i < n; i++) add_byte(d, 8'($urandom), i == n - 1);
    end
  endfunction

  task automatic push_byte(input adb_in_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
                                                 $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  // Each side keeps its own byte order; the two sides interleave in random runs.
  task automatic send_lanes();
    logic lane;
    lane = 1'($urandom_range(0, 1));
    while (lane0_q.size() + lane1_q.size() != 0) begin
      if ($urandom_range(0, 3) == 0) lane = !lane;
      if (lane && lane1_q.size() == 0) lane = 1'b0;
      if (!lane && lane0_q.size() == 0) lane = 1'b1;
      if (lane) push_byte(lane1_q.pop_front());
      else      push_byte(lane0_q.pop_front());
    end
  endtask

  task automatic run_random(input int n);
    int first;
    first = sent;
    while (sent - first < n) begin
      if ($urandom_range(0, 9) < 7) random_message(1'b0);
      if ($urandom_range(0, 9) < 7 || lane0_q.size() == 0) random_message(1'b1);
      send_lanes();
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(input logic [LimitW-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_limit = value;
  endtask

  initial begin
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Every command, the auth kinds, argument extremes and both header errors.
    build_message(1'b0, CmdSync, 32'h0, 32'h0, 32'd0, 1'b0, 0, 1'b1);
    build_message(1'b1, CmdCnxn, AllOnes, AllOnes, 32'd0, 1'b0, 0, 1'b1);
    build_message(1'b0, CmdOpen, $urandom, $urandom, 32'd1, 1'b0, 0, 1'b1);
    build_message(1'b1, CmdOkay, $urandom, $urandom, 32'd3, 1'b0, 0, 1'b1);
    build_message(1'b0, CmdClse, $urandom, $urandom, 32'd0, 1'b0, 0, 1'b1);
    build_message(1'b1, CmdWrte, $urandom, $urandom, 32'd5, 1'b0, 0, 1'b1);
    for (int k = 0; k < 5; k++) begin
      build_message(1'(k), CmdAuth, 32'(k), $urandom, 32'd0, 1'b0, 0, 1'b1);
    end
    build_message(1'b0, CmdStls, $urandom, $urandom, 32'd0, 1'b0, 0, 1'b1);
    build_message(1'b1, 32'h0, $urandom, $urandom, 32'd0, 1'b0, 0, 1'b1);
    build_message(1'b0, AllOnes, $urandom, $urandom, 32'd0, 1'b0, 0, 1'b1);
    build_message(1'b0, CmdWrte, $urandom, $urandom, 32'd2, 1'b1, 4, 1'b1);
    // An error on the segment's last byte leaves nothing to discard.
    build_message(1'b1, CmdOpen, $urandom, $urandom, 32'd0, 1'b1, 0, 1'b1);
    build_message(1'b0, CmdWrte, $urandom, $urandom, payload_cap() + 32'd1, 1'b0, 2, 1'b1);
    build_message(1'b1, CmdWrte, $urandom, $urandom, AllOnes, 1'b0, 3, 1'b1);
    build_message(1'b0, CmdWrte, $urandom, $urandom, 32'd4, 1'b0, 0, 1'b1);
    build_message(1'b1, CmdOkay, $urandom, $urandom, 32'd2, 1'b0, 0, 1'b1);
    send_lanes();

    run_random(40);
    set_limit(LimitW'(24));
    build_message(1'b0, CmdWrte, $urandom, $urandom, 32'd0, 1'b0, 0, 1'b1);
    build_message(1'b1, CmdWrte, $urandom, $urandom, 32'd1, 1'b0, 1, 1'b1);
    send_lanes();
    run_random(20);
    set_limit('0);
    run_random(20);
    set_limit(LimitW'(40));
    build_message(1'b0, CmdWrte, $urandom, $urandom, 32'd16, 1'b0, 0, 1'b1);
    build_message(1'b1, CmdWrte, $urandom, $urandom, 32'd17, 1'b0, 2, 1'b1);
    send_lanes();
    run_random(30);
    // Let every result out with the sender held back before carrying on.
    drain();
    run_random(20);
    set_limit({LimitW{1'b1}});
    run_random(20);
    set_limit(LimitW'(1048576));
    run_random(20);
    set_limit(LimitW'(23));
    run_random(10);
    set_limit(LimitW'($urandom_range(24, 300)));
    run_random(20);

    // TLS from both sides, later results marked done, then a failing header's segment end hands off.
    build_message(1'b0, CmdStls, $urandom, $urandom, 32'd0, 1'b0, 0, 1'b0);
    send_lanes();
    build_message(1'b1, CmdStls, $urandom, $urandom, 32'd0, 1'b0, 0, 1'b0);
    send_lanes();
    build_message(1'b0, CmdWrte, $urandom, $urandom, 32'd2, 1'b0, 0, 1'b0);
    send_lanes();
    build_message(1'b1, CmdOkay, $urandom, $urandom, 32'd0, 1'b1, 3, 1'b0);
    send_lanes();
    random_message(1'b0);
    random_message(1'b1);
    send_lanes();

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: adb_message_deframer_unit.f
hdl/adb_pkg.sv
hdl/adb_chan_if.sv
hdl/adb_parse_core.sv
hdl/adb_message_deframer_unit.sv
test/adb_deframer_monitor.sv
test/testbench.sv
